### design/ccrb_pkg.sv
// Package for the clock control register block.
// Holds the shared types, word indexes, reset values and small helpers.
// No dependencies.
package ccrb_pkg;

    localparam int IDX_W  = 12;  // word index taken from a 14-bit byte offset
    localparam int DIV_NW = 33;  // dividend and quotient width of the divider
    localparam int DIV_DW = 12;  // divisor width of the divider

    localparam logic [24:0] ROOT_HZ = 25'd24000000;
    localparam logic [15:0] K32_HZ  = 16'd32768;

    localparam logic [IDX_W-1:0] W_CGU0 = 12'd0;
    localparam logic [IDX_W-1:0] W_CGU1 = 12'd1;
    localparam logic [IDX_W-1:0] W_PLL  = 12'h010;
    localparam logic [IDX_W-1:0] W_SLOW = 12'h804;
    localparam logic [IDX_W-1:0] W_LOCK = 12'h06a;

    localparam logic [31:0] RST_CGU0 = 32'h0618_1813;
    localparam logic [31:0] RST_CGU1 = 32'h0000_4000;
    localparam logic [31:0] RST_PLL  = 32'h0000_8702;
    localparam logic [31:0] RST_SLOW = 32'h0000_0100;
    localparam logic [31:0] RST_LOCK = 32'h0010_0000;

    localparam logic [1:0] MODE_SYS_RD = 2'd0;
    localparam logic [1:0] MODE_SYS_WR = 2'd1;
    localparam logic [1:0] MODE_AON_RD = 2'd2;
    localparam logic [1:0] MODE_AON_WR = 2'd3;

    localparam logic [3:0] CLK_HCLK   = 4'd0;
    localparam logic [3:0] CLK_SCLK   = 4'd1;
    localparam logic [3:0] CLK_PCLK   = 4'd2;
    localparam logic [3:0] CLK_PAON   = 4'd3;
    localparam logic [3:0] CLK_TMRDIV = 4'd4;
    localparam logic [3:0] CLK_TMR0   = 4'd5;
    localparam logic [3:0] CLK_TMR1   = 4'd6;
    localparam logic [3:0] CLK_TMR2   = 4'd7;
    localparam logic [3:0] CLK_UART0  = 4'd8;
    localparam logic [3:0] CLK_UART1  = 4'd9;
    localparam logic [3:0] CLK_SPI    = 4'd10;
    localparam logic [3:0] CLK_USB    = 4'd11;
    localparam logic [3:0] CLK_ADC    = 4'd12;
    localparam logic [3:0] CLK_32K    = 4'd13;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_FREQ = 1'b1;

    typedef enum logic [2:0] {
        OP_PLL,
        OP_HCLK,
        OP_PCLK,
        OP_PAON,
        OP_TMR,
        OP_USB,
        OP_ADC
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_PREP,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic             clr_en;
        logic [IDX_W-1:0] clr_idx;
        logic             acc_en;
        logic             prep;
        logic             div_start;
        op_t              div_op;
        logic             load_rd;
        logic             load_freq;
        logic [3:0]       emit_id;
    } cmd_t;

    typedef struct packed {
        logic is_wr;
        logic trig;
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic logic [31:0] sys_reset_word(input logic [IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            W_CGU0:  v = RST_CGU0;
            W_CGU1:  v = RST_CGU1;
            W_PLL:   v = RST_PLL;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] aon_reset_word(input logic [IDX_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            W_SLOW:  v = RST_SLOW;
            W_LOCK:  v = RST_LOCK;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // A divisor field of zero counts as one.
    function automatic logic [3:0] nz4(input logic [3:0] v);
        return (v == 4'd0) ? 4'd1 : v;
    endfunction

    function automatic logic [5:0] nz6(input logic [5:0] v);
        return (v == 6'd0) ? 6'd1 : v;
    endfunction

endpackage

### design/clock_control_register_block_unit.sv
// Clock control register block: bus access decoding, two register pages and
// the clock frequency recomputation.
// Usage:
//   The input channel (in_valid/in_stall) carries one bus access per word:
//   mode, byte_offset and write_data. The output channel (out_valid/out_stall)
//   carries result words: kind, clock_id, result_value and last.
//   A read word passes the page's read register, then the output register.
//   A write that is out of range, or to a non-trigger word, gives no result
//   and the next access may follow in the next cycle.
//   A write to a trigger word (cgu0, cgu1, pll control, slow select, pll lock)
//   yields fourteen frequency words. Seven divisions share one restoring
//   divider that produces one quotient bit per cycle; after the last division
//   the fourteen words leave one per cycle while the output is not stalled.
//   Only one access is in flight at a time; in_stall stays high until it is
//   finished and its last result is in the output register.
//   After reset a clearing pass walks every word index below AON_WORDS and
//   loads the reset values into both pages, with in_stall high throughout.
//   A stalled output word holds; the block waits for the receiver.
// Depends on ccrb_pkg, ccrb_ctl and ccrb_dp.
module clock_control_register_block_unit #(
    parameter int SYS_WORDS = 64,
    parameter int AON_WORDS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [13:0] byte_offset,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [3:0]  clock_id,
    output logic [31:0] result_value,
    output logic        last
);

    ccrb_pkg::cmd_t cmd;
    ccrb_pkg::sts_t sts;

    ccrb_ctl #(.AON_WORDS(AON_WORDS)) u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ccrb_dp #(.SYS_WORDS(SYS_WORDS), .AON_WORDS(AON_WORDS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .byte_offset  (byte_offset),
        .write_data   (write_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .kind         (kind),
        .clock_id     (clock_id),
        .result_value (result_value),
        .last         (last)
    );

endmodule

### design/ccrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ccrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/ccrb_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ccrb_pkg for the operand widths.
module ccrb_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ccrb_pkg::DIV_NW-1:0] dividend,
    input  logic [ccrb_pkg::DIV_DW-1:0] divisor,
    output logic                        done,
    output logic [ccrb_pkg::DIV_NW-1:0] quotient
);

    localparam int NW = ccrb_pkg::DIV_NW;
    localparam int DW = ccrb_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] den_reg;
    logic [NW-1:0] q_reg;
    logic [DW:0]   trial;
    logic          ge;

    assign trial    = {rem_reg, q_reg[NW-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= CW'(cnt_reg + 1'b1);
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= divisor;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### design/ccrb_dp.sv
// Datapath: both register pages, clock setting copies, divider, result registers.
// Depends on ccrb_pkg, ccrb_ram and ccrb_div.
module ccrb_dp #(
    parameter int SYS_WORDS = 64,
    parameter int AON_WORDS = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccrb_pkg::cmd_t       cmd,
    output ccrb_pkg::sts_t       sts,
    input  logic [1:0]           mode,
    input  logic [13:0]          byte_offset,
    input  logic [31:0]          write_data,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic                 kind,
    output logic [3:0]           clock_id,
    output logic [31:0]          result_value,
    output logic                 last
);

    localparam int IW     = ccrb_pkg::IDX_W;
    localparam int NW     = ccrb_pkg::DIV_NW;
    localparam int DW     = ccrb_pkg::DIV_DW;
    localparam int SYS_AW = $clog2(SYS_WORDS);
    localparam int AON_AW = $clog2(AON_WORDS);

    logic [IW-1:0] idx;
    logic          is_aon;
    logic          is_wr;
    logic          sys_inr;
    logic          aon_inr;
    logic          inr;
    logic          clr_sys;
    logic          clr_aon;

    logic              sys_we;
    logic              aon_we;
    logic [SYS_AW-1:0] sys_waddr;
    logic [AON_AW-1:0] aon_waddr;
    logic [31:0]       sys_wdata;
    logic [31:0]       aon_wdata;
    logic [31:0]       sys_q;
    logic [31:0]       aon_q;

    logic [31:0] c0_reg;
    logic [31:0] c1_reg;
    logic [31:0] pc_reg;
    logic [31:0] lk_reg;
    logic        rd_aon_reg;
    logic        rd_inr_reg;

    logic [NW-1:0] pll_num_reg;
    logic [DW-1:0] pll_den_reg;
    logic [NW-1:0] adc_num_reg;
    logic [NW-1:0] pll_reg;
    logic [NW-1:0] hclk_reg;
    logic [NW-1:0] pclk_reg;
    logic [NW-1:0] paon_reg;
    logic [NW-1:0] tmr_reg;
    logic [NW-1:0] usb_reg;
    logic [NW-1:0] adc_reg;

    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_done;
    logic [NW-1:0] div_q;

    logic          out_valid_reg;
    logic          kind_reg;
    logic [3:0]    id_reg;
    logic [31:0]   val_reg;
    logic          last_reg;
    logic [NW-1:0] freq;

    assign idx     = byte_offset[13:2];
    assign is_aon  = mode[1];
    assign is_wr   = mode[0];
    assign sys_inr = {1'b0, idx} < (IW+1)'(SYS_WORDS);
    assign aon_inr = {1'b0, idx} < (IW+1)'(AON_WORDS);
    assign inr     = is_aon ? aon_inr : sys_inr;

    assign clr_sys = {1'b0, cmd.clr_idx} < (IW+1)'(SYS_WORDS);
    assign clr_aon = {1'b0, cmd.clr_idx} < (IW+1)'(AON_WORDS);

    always_comb
    begin
        sts.is_wr    = is_wr;
        sts.trig     = 1'b0;
        sts.div_done = div_done;
        sts.out_free = !out_valid_reg || !out_stall;
        if (is_wr && inr)
        begin
            if (is_aon)
            begin
                sts.trig = (idx == ccrb_pkg::W_SLOW) || (idx == ccrb_pkg::W_LOCK);
            end
            else
            begin
                sts.trig = (idx == ccrb_pkg::W_CGU0) || (idx == ccrb_pkg::W_CGU1) ||
                           (idx == ccrb_pkg::W_PLL);
            end
        end
    end

    // The clearing pass and ordinary writes share each page's write port.
    always_comb
    begin
        if (cmd.clr_en)
        begin
            sys_we    = clr_sys;
            aon_we    = clr_aon;
            sys_waddr = cmd.clr_idx[SYS_AW-1:0];
            aon_waddr = cmd.clr_idx[AON_AW-1:0];
            sys_wdata = ccrb_pkg::sys_reset_word(cmd.clr_idx);
            aon_wdata = ccrb_pkg::aon_reset_word(cmd.clr_idx);
        end
        else
        begin
            sys_we    = cmd.acc_en && is_wr && !is_aon && sys_inr;
            aon_we    = cmd.acc_en && is_wr && is_aon && aon_inr;
            sys_waddr = idx[SYS_AW-1:0];
            aon_waddr = idx[AON_AW-1:0];
            sys_wdata = write_data;
            aon_wdata = write_data;
        end
    end

    ccrb_ram #(.WIDTH(32), .DEPTH(SYS_WORDS)) u_sys_ram (
        .clk   (clk),
        .we    (sys_we),
        .waddr (sys_waddr),
        .wdata (sys_wdata),
        .re    (cmd.acc_en && !is_wr && !is_aon && sys_inr),
        .raddr (idx[SYS_AW-1:0]),
        .rdata (sys_q)
    );

    ccrb_ram #(.WIDTH(32), .DEPTH(AON_WORDS)) u_aon_ram (
        .clk   (clk),
        .we    (aon_we),
        .waddr (aon_waddr),
        .wdata (aon_wdata),
        .re    (cmd.acc_en && !is_wr && is_aon && aon_inr),
        .raddr (idx[AON_AW-1:0]),
        .rdata (aon_q)
    );

    // Copies of the four words the clock tree depends on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= ccrb_pkg::RST_CGU0;
            c1_reg <= ccrb_pkg::RST_CGU1;
            pc_reg <= ccrb_pkg::RST_PLL;
            lk_reg <= ccrb_pkg::RST_LOCK;
        end
        else if (cmd.acc_en && is_wr)
        begin
            if (!is_aon && idx == ccrb_pkg::W_CGU0)
            begin
                c0_reg <= write_data;
            end
            if (!is_aon && idx == ccrb_pkg::W_CGU1)
            begin
                c1_reg <= write_data;
            end
            if (!is_aon && idx == ccrb_pkg::W_PLL)
            begin
                pc_reg <= write_data;
            end
            if (is_aon && idx == ccrb_pkg::W_LOCK)
            begin
                lk_reg <= write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            rd_aon_reg <= is_aon;
            rd_inr_reg <= inr;
        end
        if (cmd.prep)
        begin
            // The PLL reads zero unless it is enabled and locked.
            if (c1_reg[14] && lk_reg[20])
            begin
                pll_num_reg <= NW'(ccrb_pkg::ROOT_HZ) * NW'(pc_reg[14:7]);
            end
            else
            begin
                pll_num_reg <= '0;
            end
            pll_den_reg <= DW'(ccrb_pkg::nz6(pc_reg[6:1])) *
                           DW'(ccrb_pkg::nz6(pc_reg[20:15]));
            adc_num_reg <= NW'(ccrb_pkg::ROOT_HZ) * NW'(c0_reg[23:20]);
        end
        if (div_done)
        begin
            case (cmd.div_op)
                ccrb_pkg::OP_PLL:  pll_reg  <= div_q;
                ccrb_pkg::OP_HCLK: hclk_reg <= div_q;
                ccrb_pkg::OP_PCLK: pclk_reg <= div_q;
                ccrb_pkg::OP_PAON: paon_reg <= div_q;
                ccrb_pkg::OP_TMR:  tmr_reg  <= div_q;
                ccrb_pkg::OP_USB:  usb_reg  <= div_q;
                default:           adc_reg  <= div_q;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.div_op)
            ccrb_pkg::OP_PLL:
            begin
                div_num = pll_num_reg;
                div_den = pll_den_reg;
            end
            ccrb_pkg::OP_HCLK:
            begin
                div_num = c1_reg[14] ? pll_reg : NW'(ccrb_pkg::ROOT_HZ);
                div_den = c1_reg[14] ? DW'(ccrb_pkg::nz4(c0_reg[3:0])) : DW'(1);
            end
            ccrb_pkg::OP_PCLK:
            begin
                div_num = hclk_reg;
                div_den = DW'(ccrb_pkg::nz4(c0_reg[7:4]));
            end
            ccrb_pkg::OP_PAON:
            begin
                div_num = hclk_reg;
                div_den = DW'(ccrb_pkg::nz4(c0_reg[11:8]));
            end
            ccrb_pkg::OP_TMR:
            begin
                div_num = NW'(ccrb_pkg::ROOT_HZ);
                div_den = DW'(ccrb_pkg::nz4(c0_reg[15:12]));
            end
            ccrb_pkg::OP_USB:
            begin
                div_num = pll_reg;
                div_den = DW'(ccrb_pkg::nz4(c0_reg[19:16]));
            end
            default:
            begin
                div_num = adc_num_reg;
                div_den = DW'(ccrb_pkg::nz4(c0_reg[27:24]));
            end
        endcase
    end

    ccrb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        unique case (cmd.emit_id)
            ccrb_pkg::CLK_HCLK:   freq = hclk_reg;
            ccrb_pkg::CLK_SCLK:   freq = NW'(ccrb_pkg::ROOT_HZ);
            ccrb_pkg::CLK_PCLK:   freq = pclk_reg;
            ccrb_pkg::CLK_PAON:   freq = paon_reg;
            ccrb_pkg::CLK_TMRDIV: freq = tmr_reg;
            ccrb_pkg::CLK_TMR0:   freq = c1_reg[15] ? NW'(ccrb_pkg::K32_HZ) : tmr_reg;
            ccrb_pkg::CLK_TMR1:   freq = c1_reg[16] ? NW'(ccrb_pkg::K32_HZ) : tmr_reg;
            ccrb_pkg::CLK_TMR2:   freq = c1_reg[17] ? NW'(ccrb_pkg::K32_HZ) : tmr_reg;
            ccrb_pkg::CLK_UART0:  freq = c1_reg[19] ? hclk_reg : NW'(ccrb_pkg::ROOT_HZ);
            ccrb_pkg::CLK_UART1:  freq = c1_reg[20] ? hclk_reg : NW'(ccrb_pkg::ROOT_HZ);
            ccrb_pkg::CLK_SPI:    freq = c1_reg[22] ? hclk_reg : NW'(ccrb_pkg::ROOT_HZ);
            ccrb_pkg::CLK_USB:    freq = usb_reg;
            ccrb_pkg::CLK_ADC:    freq = adc_reg;
            default:              freq = NW'(ccrb_pkg::K32_HZ);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_rd || cmd.load_freq)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rd)
        begin
            kind_reg <= ccrb_pkg::KIND_READ;
            id_reg   <= 4'd0;
            val_reg  <= !rd_inr_reg ? 32'd0 : (rd_aon_reg ? aon_q : sys_q);
            last_reg <= 1'b1;
        end
        else if (cmd.load_freq)
        begin
            kind_reg <= ccrb_pkg::KIND_FREQ;
            id_reg   <= cmd.emit_id;
            val_reg  <= freq[31:0];
            last_reg <= cmd.emit_id == ccrb_pkg::CLK_32K;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign clock_id     = id_reg;
    assign result_value = val_reg;
    assign last         = last_reg;

endmodule

### design/ccrb_ctl.sv
// Controller: clearing pass, access decode, division sequence and result emission.
// Depends on ccrb_pkg.
module ccrb_ctl #(
    parameter int AON_WORDS = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ccrb_pkg::sts_t sts,
    output ccrb_pkg::cmd_t cmd
);

    localparam int IW = ccrb_pkg::IDX_W;

    ccrb_pkg::state_t st_reg;
    ccrb_pkg::state_t st_next;
    ccrb_pkg::op_t    op_reg;
    ccrb_pkg::op_t    op_next;
    logic [IW-1:0]    clr_reg;
    logic [IW-1:0]    clr_next;
    logic [3:0]       id_reg;
    logic [3:0]       id_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ccrb_pkg::S_CLEAR;
            op_reg  <= ccrb_pkg::OP_PLL;
            clr_reg <= '0;
            id_reg  <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            op_reg  <= op_next;
            clr_reg <= clr_next;
            id_reg  <= id_next;
        end
    end

    always_comb
    begin
        st_next       = st_reg;
        op_next       = op_reg;
        clr_next      = clr_reg;
        id_next       = id_reg;
        in_stall      = 1'b1;
        cmd.clr_en    = 1'b0;
        cmd.clr_idx   = clr_reg;
        cmd.acc_en    = 1'b0;
        cmd.prep      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_op    = op_reg;
        cmd.load_rd   = 1'b0;
        cmd.load_freq = 1'b0;
        cmd.emit_id   = id_reg;
        unique case (st_reg)
            ccrb_pkg::S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                clr_next   = IW'(clr_reg + 1'b1);
                if (clr_reg == IW'(AON_WORDS - 1))
                begin
                    st_next = ccrb_pkg::S_IDLE;
                end
            end
            ccrb_pkg::S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.acc_en = in_valid;
                if (in_valid)
                begin
                    if (!sts.is_wr)
                    begin
                        st_next = ccrb_pkg::S_RD;
                    end
                    else if (sts.trig)
                    begin
                        st_next = ccrb_pkg::S_PREP;
                    end
                end
            end
            ccrb_pkg::S_RD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_rd = 1'b1;
                    st_next     = ccrb_pkg::S_IDLE;
                end
            end
            ccrb_pkg::S_PREP:
            begin
                cmd.prep = 1'b1;
                op_next  = ccrb_pkg::OP_PLL;
                st_next  = ccrb_pkg::S_DIV_GO;
            end
            ccrb_pkg::S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                st_next       = ccrb_pkg::S_DIV_WAIT;
            end
            ccrb_pkg::S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    if (op_reg == ccrb_pkg::OP_ADC)
                    begin
                        id_next = '0;
                        st_next = ccrb_pkg::S_EMIT;
                    end
                    else
                    begin
                        op_next = ccrb_pkg::op_t'(3'(op_reg + 1'b1));
                        st_next = ccrb_pkg::S_DIV_GO;
                    end
                end
            end
            ccrb_pkg::S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_freq = 1'b1;
                    id_next       = 4'(id_reg + 1'b1);
                    if (id_reg == ccrb_pkg::CLK_32K)
                    begin
                        st_next = ccrb_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = ccrb_pkg::S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_adc_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ccrb_pkg::S_DIV_WAIT && sts.div_done && op_reg == ccrb_pkg::OP_ADC)
        |=> (st_reg == ccrb_pkg::S_EMIT && id_reg == 4'd0))
        else $error("emission did not start after the last division");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ccrb_pkg::S_CLEAR) |-> (!cmd.load_rd && !cmd.load_freq && !cmd.acc_en))
        else $error("activity during the clearing pass");

    a_last_word_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ccrb_pkg::S_EMIT && sts.out_free && id_reg == ccrb_pkg::CLK_32K)
        |=> (st_reg == ccrb_pkg::S_IDLE))
        else $error("controller did not return to idle after the last frequency");
`endif

endmodule
